FILE: src/drpd_pkg.sv
// shared constants, types and direction tables for the record period digest
// no dependencies; used by every module of the block
package drpd_pkg;

	localparam int RecW      = 64;
	localparam int NibW      = 4;
	localparam int Nibbles   = 16;
	localparam int Rotations = 15;
	localparam int GroupSize = 5;
	localparam int Groups    = Rotations / GroupSize;
	localparam int CntW      = 5;
	localparam int IdxW      = 4;
	localparam int SumW      = 6;
	localparam int PartW     = 4;
	localparam int PartSize  = 4;
	localparam int Parts     = Nibbles / PartSize;
	localparam int DirW      = 3;

	typedef logic [CntW-1:0]         cnt_t;
	typedef logic [IdxW-1:0]         idx_t;
	typedef logic [NibW-1:0]         nib_t;
	typedef logic signed [1:0]       unit_t;
	typedef logic signed [PartW-1:0] part_t;
	typedef logic signed [SumW-1:0]  sum_t;

	// digest of a set of rotation counts
	typedef struct packed {
		cnt_t lo;
		cnt_t hi;
		idx_t idx;
	} scan_t;

	localparam logic [DirW-1:0] DirSw = 3'd0;
	localparam logic [DirW-1:0] DirS  = 3'd1;
	localparam logic [DirW-1:0] DirSe = 3'd2;
	localparam logic [DirW-1:0] DirE  = 3'd3;
	localparam logic [DirW-1:0] DirNe = 3'd4;
	localparam logic [DirW-1:0] DirN  = 3'd5;
	localparam logic [DirW-1:0] DirNw = 3'd6;
	localparam logic [DirW-1:0] DirW8 = 3'd7;

	// x step of one nibble, zero when the moved bit is clear
	function automatic unit_t step_dx(nib_t s);
		unit_t d;
		d = '0;
		if (s[NibW-1]) begin
			unique case (s[DirW-1:0])
				DirSw, DirNw, DirW8: d = -2'sd1;
				DirS, DirN:          d = 2'sd0;
				DirSe, DirE, DirNe:  d = 2'sd1;
				default:             d = 2'sd0;
			endcase
		end
		return d;
	endfunction

	// y step of one nibble, zero when the moved bit is clear
	function automatic unit_t step_dy(nib_t s);
		unit_t d;
		d = '0;
		if (s[NibW-1]) begin
			unique case (s[DirW-1:0])
				DirSw, DirS, DirSe: d = -2'sd1;
				DirE, DirW8:        d = 2'sd0;
				DirNe, DirN, DirNw: d = 2'sd1;
				default:            d = 2'sd0;
			endcase
		end
		return d;
	endfunction

endpackage

FILE: src/drpd_rot.sv
// rotation compare: per-nibble difference flags, then differing-nibble counts
// depends on drpd_pkg
module drpd_rot (
	input  logic                   clk,
	input  logic [drpd_pkg::RecW-1:0] record_s1,
	output drpd_pkg::cnt_t         cnt_s3 [drpd_pkg::Rotations]
);
	import drpd_pkg::*;

	logic [Nibbles-1:0] diff;
	logic [Nibbles-1:0] diff_all [Rotations];
	logic [Nibbles-1:0] flags_s2 [Rotations];

	// rotation by r+1 nibbles compares nibble i against nibble i+r+1
	always_comb begin
		for (int r = 0; r < Rotations; r++) begin
			diff = '0;
			for (int i = 0; i < Nibbles; i++) begin
				diff[i] = record_s1[NibW*i +: NibW] !=
					record_s1[NibW*((i + r + 1) % Nibbles) +: NibW];
			end
			diff_all[r] = diff;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < Rotations; r++) begin
			flags_s2[r] <= diff_all[r];
			cnt_s3[r]   <= CntW'($countones(flags_s2[r]));
		end
	end

endmodule

FILE: src/drpd_scan.sv
// least and greatest count over the rotations, first index of the least
// depends on drpd_pkg; two stages: group reduce, then final combine
module drpd_scan (
	input  logic            clk,
	input  drpd_pkg::cnt_t  cnt_s3 [drpd_pkg::Rotations],
	output drpd_pkg::scan_t scan_s5
);
	import drpd_pkg::*;

	scan_t grp [Groups];
	scan_t grp_s4 [Groups];
	scan_t fin;

	// strict less keeps the lowest index on ties
	always_comb begin
		for (int g = 0; g < Groups; g++) begin
			grp[g].lo  = cnt_s3[g*GroupSize];
			grp[g].hi  = cnt_s3[g*GroupSize];
			grp[g].idx = IdxW'(g*GroupSize);
			for (int k = 1; k < GroupSize; k++) begin
				if (cnt_s3[g*GroupSize + k] < grp[g].lo) begin
					grp[g].lo  = cnt_s3[g*GroupSize + k];
					grp[g].idx = IdxW'(g*GroupSize + k);
				end
				if (cnt_s3[g*GroupSize + k] > grp[g].hi) begin
					grp[g].hi = cnt_s3[g*GroupSize + k];
				end
			end
		end
	end

	always_comb begin
		fin = grp_s4[0];
		for (int g = 1; g < Groups; g++) begin
			if (grp_s4[g].lo < fin.lo) begin
				fin.lo  = grp_s4[g].lo;
				fin.idx = grp_s4[g].idx;
			end
			if (grp_s4[g].hi > fin.hi) begin
				fin.hi = grp_s4[g].hi;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < Groups; g++) begin
			grp_s4[g] <= grp[g];
		end
		scan_s5 <= fin;
	end

endmodule

FILE: src/drpd_disp.sv
// x and y displacement sums over all 16 steps, delayed to match the scan
// depends on drpd_pkg
module drpd_disp (
	input  logic                      clk,
	input  logic [drpd_pkg::RecW-1:0] record_s1,
	output drpd_pkg::sum_t            sx_s5,
	output drpd_pkg::sum_t            sy_s5
);
	import drpd_pkg::*;

	part_t px [Parts];
	part_t py [Parts];
	part_t px_s2 [Parts];
	part_t py_s2 [Parts];
	sum_t  tx;
	sum_t  ty;
	sum_t  sx_s3;
	sum_t  sy_s3;
	sum_t  sx_s4;
	sum_t  sy_s4;

	// partial sums over groups of four steps
	always_comb begin
		for (int p = 0; p < Parts; p++) begin
			px[p] = '0;
			py[p] = '0;
			for (int k = 0; k < PartSize; k++) begin
				px[p] = px[p] + PartW'(step_dx(record_s1[NibW*(p*PartSize + k) +: NibW]));
				py[p] = py[p] + PartW'(step_dy(record_s1[NibW*(p*PartSize + k) +: NibW]));
			end
		end
	end

	always_comb begin
		tx = '0;
		ty = '0;
		for (int p = 0; p < Parts; p++) begin
			tx = tx + SumW'(px_s2[p]);
			ty = ty + SumW'(py_s2[p]);
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < Parts; p++) begin
			px_s2[p] <= px[p];
			py_s2[p] <= py[p];
		end
		sx_s3 <= tx;
		sy_s3 <= ty;
		sx_s4 <= sx_s3;
		sy_s4 <= sy_s3;
		sx_s5 <= sx_s4;
		sy_s5 <= sy_s4;
	end

endmodule

FILE: src/displacement_record_period_digest.sv
// displacement record period digest: one 64-bit record word in, one digest word out
// the done strobe is valid_s5: an accepted word's valid bit passes valid_s1 to valid_s5
// throughput: one word per cycle, set by the five-stage pipeline; busy stays low
// the receiver cannot stall, so results are shown for exactly one cycle on done
// reset clears only the valid bits of the pipeline; depends on drpd_pkg and submodules
module displacement_record_period_digest (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [drpd_pkg::RecW-1:0] record,
	output logic                      busy,
	output logic                      done,
	output drpd_pkg::cnt_t            mismatch_min,
	output drpd_pkg::cnt_t            mismatch_max,
	output drpd_pkg::idx_t            period_index,
	output drpd_pkg::sum_t            shift_x,
	output drpd_pkg::sum_t            shift_y
);
	import drpd_pkg::*;

	logic [RecW-1:0] record_s1;
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	logic            valid_s4;
	logic            valid_s5;
	cnt_t            cnt_s3 [Rotations];
	scan_t           scan_s5;
	sum_t            sx_s5;
	sum_t            sy_s5;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		record_s1 <= record;
	end

	drpd_rot u_rot (
		.clk       (clk),
		.record_s1 (record_s1),
		.cnt_s3    (cnt_s3)
	);

	drpd_scan u_scan (
		.clk     (clk),
		.cnt_s3  (cnt_s3),
		.scan_s5 (scan_s5)
	);

	drpd_disp u_disp (
		.clk       (clk),
		.record_s1 (record_s1),
		.sx_s5     (sx_s5),
		.sy_s5     (sy_s5)
	);

	assign done         = valid_s5;
	assign mismatch_min = scan_s5.lo;
	assign mismatch_max = scan_s5.hi;
	assign period_index = scan_s5.idx;
	assign shift_x      = sx_s5;
	assign shift_y      = sy_s5;

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> mismatch_min <= mismatch_max)
		else $error("least count above greatest count");

	a_full_mismatch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		done && mismatch_min == CntW'(Nibbles) |-> period_index == '0)
		else $error("all rotations differ but index is not zero");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> period_index < IdxW'(Rotations))
		else $error("period index out of range");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> shift_x >= -SumW'(Nibbles) && shift_x <= SumW'(Nibbles)
			&& shift_y >= -SumW'(Nibbles) && shift_y <= SumW'(Nibbles))
		else $error("displacement sum out of range");

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##4 done)
		else $error("accepted word lost in pipeline");

endmodule

FILE: verif/tb_displacement_record_period_digest.sv
// testbench for displacement_record_period_digest: directed and random record words,
// each digest checked against a local predictor; depends on drpd_pkg and the block
module tb_displacement_record_period_digest;
	timeunit 1ns;
	timeprecision 1ps;

	import drpd_pkg::*;

	localparam int IdleLimit = 1000;
	localparam int PrintCap  = 40;

	typedef struct packed {
		cnt_t lo;
		cnt_t hi;
		idx_t idx;
		sum_t sx;
		sum_t sy;
	} digest_t;

	typedef struct {
		logic [RecW-1:0] rec;
		int              gap_after;
		bit              drain;
	} record_word_t;

	logic            clk    = 1'b0;
	logic            arst_n = 1'b0;
	logic            start  = 1'b0;
	logic [RecW-1:0] record = '0;
	logic            busy;
	logic            done;
	cnt_t            mismatch_min;
	cnt_t            mismatch_max;
	idx_t            period_index;
	sum_t            shift_x;
	sum_t            shift_y;

	record_word_t pending_q[$];
	digest_t      digest_q[$];
	int           wait_cnt;
	int           idle_cycles = 0;
	int           n_errors    = 0;

	displacement_record_period_digest u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.record       (record),
		.busy         (busy),
		.done         (done),
		.mismatch_min (mismatch_min),
		.mismatch_max (mismatch_max),
		.period_index (period_index),
		.shift_x      (shift_x),
		.shift_y      (shift_y)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// rotation scan and displacement sums for one record word
	function automatic digest_t predict_digest(logic [RecW-1:0] rec);
		digest_t         d;
		logic [RecW-1:0] rot;
		logic [RecW-1:0] diff;
		logic [NibW-1:0] nib;
		int              cnt;
		int              sx;
		int              sy;
		d.lo = cnt_t'(Nibbles);
		d.hi = '0;
		d.idx = '0;
		rot = rec;
		sx = 0;
		sy = 0;
		for (int j = 0; j < Rotations; j++) begin
			rot = {rot[NibW-1:0], rot[RecW-1:NibW]};
			diff = rec ^ rot;
			cnt = 0;
			for (int i = 0; i < Nibbles; i++)
				if (diff[i*NibW +: NibW] != '0) cnt++;
			// strict compare keeps the lowest rotation on ties
			if (cnt < d.lo) begin
				d.lo = cnt_t'(cnt);
				d.idx = idx_t'(j);
			end
			if (cnt > d.hi) d.hi = cnt_t'(cnt);
		end
		for (int i = 0; i < Nibbles; i++) begin
			nib = rec[i*NibW +: NibW];
			if (nib[NibW-1]) begin
				case (nib[DirW-1:0])
					DirSw: begin sx -= 1; sy -= 1; end
					DirS:  sy -= 1;
					DirSe: begin sx += 1; sy -= 1; end
					DirE:  sx += 1;
					DirNe: begin sx += 1; sy += 1; end
					DirN:  sy += 1;
					DirNw: begin sx -= 1; sy += 1; end
					DirW8: sx -= 1;
					default: ;
				endcase
			end
		end
		d.sx = sum_t'(sx);
		d.sy = sum_t'(sy);
		return d;
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		if (n_errors < PrintCap)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	task automatic add_word(logic [RecW-1:0] rec, int gap, bit drain);
		record_word_t w;
		w.rec = rec;
		w.gap_after = gap;
		w.drain = drain;
		pending_q.push_back(w);
	endtask

	// record built from a repeating pattern of the given period, some nibbles broken
	function automatic logic [RecW-1:0] tiled_record(int period, logic [NibW-1:0] mask,
			int breaks);
		logic [NibW-1:0] pat[Nibbles];
		logic [RecW-1:0] rec;
		for (int k = 0; k < Nibbles; k++) pat[k] = NibW'($urandom) & mask;
		for (int i = 0; i < Nibbles; i++) rec[i*NibW +: NibW] = pat[i % period];
		for (int b = 0; b < breaks; b++)
			rec[$urandom_range(0, Nibbles-1)*NibW +: NibW] = NibW'($urandom);
		return rec;
	endfunction

	function automatic logic [RecW-1:0] random_record();
		logic [RecW-1:0] rec;
		logic [NibW-1:0] a;
		logic [NibW-1:0] b;
		int              pick;
		pick = $urandom_range(0, 9);
		rec = {$urandom, $urandom};
		if (pick >= 3 && pick <= 6) begin
			rec = tiled_record($urandom_range(1, Nibbles),
				($urandom_range(0, 3) == 0) ? NibW'($urandom) : 4'hF,
				($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
		end else if (pick == 7) begin
			// sparse: few nonzero steps
			rec = '0;
			for (int k = $urandom_range(1, 3); k > 0; k--)
				rec[$urandom_range(0, Nibbles-1)*NibW +: NibW] = NibW'($urandom);
		end else if (pick == 8) begin
			// two-symbol alphabet
			a = NibW'($urandom);
			b = NibW'($urandom);
			for (int i = 0; i < Nibbles; i++) rec[i*NibW +: NibW] = $urandom_range(0, 1) ? a : b;
		end else if (pick == 9) begin
			// every step moved, directions biased to push the sums outward
			a = NibW'($urandom_range(0, 7));
			for (int i = 0; i < Nibbles; i++)
				rec[i*NibW +: NibW] = {1'b1, ($urandom_range(0, 3) == 0) ? 3'($urandom) : a[2:0]};
		end
		return rec;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: raise start for the next word once the previous one is taken
	always @(posedge clk or negedge arst_n) begin : drive
		logic take;
		if (!arst_n) begin
			start <= 1'b0;
			record <= '0;
			wait_cnt <= 0;
		end else begin
			take = start && !busy;
			if (take) digest_q.push_back(predict_digest(record));
			if (start && !take) begin
				// held off, keep the word on the bus
			end else if (wait_cnt != 0) begin
				wait_cnt <= wait_cnt - 1;
				start <= 1'b0;
			end else if (pending_q.size() != 0 &&
					(!pending_q[0].drain || (digest_q.size() == 0 && !done))) begin
				start <= 1'b1;
				record <= pending_q[0].rec;
				wait_cnt <= pending_q[0].gap_after;
				pending_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done strobe carries one digest word
	always @(posedge clk) begin : watch
		digest_t want;
		if (arst_n && done) begin
			if (digest_q.size() == 0) begin
				flag_mismatch("unexpected word, mismatch_min", mismatch_min, -1);
			end else begin
				want = digest_q.pop_front();
				if (mismatch_min !== want.lo) flag_mismatch("mismatch_min", mismatch_min, want.lo);
				if (mismatch_max !== want.hi) flag_mismatch("mismatch_max", mismatch_max, want.hi);
				if (period_index !== want.idx)
					flag_mismatch("period_index", period_index, want.idx);
				if (shift_x !== want.sx)
					flag_mismatch("shift_x", $signed(shift_x), $signed(want.sx));
				if (shift_y !== want.sy)
					flag_mismatch("shift_y", $signed(shift_y), $signed(want.sy));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IdleLimit) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int burst;
		burst = 0;

		// directed words: field extremes, every direction, ties and periods
		add_word(64'h0, 0, 1'b0);
		add_word(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
		add_word(64'h0123_4567_89AB_CDEF, 1, 1'b0);
		for (int n = 8; n < 16; n++) add_word({Nibbles{NibW'(n)}}, 0, 1'b0);
		add_word(64'h7777_7777_7777_7777, 2, 1'b0);
		add_word(64'h0000_0000_0000_0001, 0, 1'b0);
		add_word(64'h8000_0000_0000_0000, 0, 1'b0);
		add_word(64'h8C8C_8C8C_8C8C_8C8C, 0, 1'b0);
		add_word(64'h0F3A_0F3A_0F3A_0F3A, 5, 1'b0);
		add_word(64'h1234_5678_1234_5678, 0, 1'b0);
		add_word(64'hFEDC_BA98_7654_3210, 0, 1'b0);
		add_word(64'hAAAA_5555_AAAA_5555, 0, 1'b0);
		add_word(64'h9D9_D9D9_D9D9_D9D9D, 0, 1'b0);

		for (int k = 0; k < 400; k++) begin
			if (burst == 0 && $urandom_range(0, 7) == 0) burst = $urandom_range(20, 40);
			// first random word waits for the pipeline to empty
			add_word(random_record(), (burst != 0) ? 0 : pick_gap(),
				k == 0 || $urandom_range(0, 99) == 0);
			if (burst != 0) burst--;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start) @(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
